@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the port-level checker (mscc_checker.sv) of the RTL folder.
// Each macro expects i_clk and the active-low reset i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/mscc_pkg.sv @@
// Package of the motor short-circuit checker: sizes, codes and the command type.
// Used by every module of the block; depends on nothing.
package mscc_pkg;

    // Table and averaging sizes.
    localparam int MOTOR_ROWS       = 6;
    localparam int MOTOR_COLS       = 8;
    localparam int BASELINE_SAMPLES = 50;
    localparam int TABLE_SIZE       = MOTOR_ROWS * MOTOR_COLS;
    localparam int ADDR_W           = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

    // Field widths.
    localparam int MODE_W    = 3;
    localparam int IDX_W     = 3;
    localparam int SAMPLE_W  = 16;
    localparam int CODE_W    = 2;
    localparam int STATUS_W  = 3;
    localparam int THR_W     = 15;
    localparam int CNT6_W    = 6;
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 24;

    // Baseline accumulator and divide-by-constant reciprocal.
    localparam int CNT_W     = $clog2(BASELINE_SAMPLES + 1);
    localparam int SUM_W     = SAMPLE_W + CNT_W;
    localparam int DIV_SHIFT = SUM_W + CNT_W;
    localparam logic [DIV_SHIFT:0] DIV_MULT =
        (DIV_SHIFT + 1)'(((64'd1 << DIV_SHIFT) + 64'(BASELINE_SAMPLES) - 64'd1)
                         / 64'(BASELINE_SAMPLES));

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_COUNT_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH     = 2'd2;

    localparam logic [THR_W-1:0]  RST_IDLE_THRESHOLD    = 15'd10;
    localparam logic [CNT6_W-1:0] RST_FAULT_COUNT_LIMIT = 6'd15;
    localparam logic [CNT6_W-1:0] RST_WINDOW_LENGTH     = 6'd20;

    // Input modes.
    localparam logic [MODE_W-1:0] MODE_BASELINE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_START    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SAMPLE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WRITE    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ     = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PASSED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SHORT     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd4;

    // Health codes.
    localparam logic [CODE_W-1:0] CODE_FUNCTIONAL = 2'd0;
    localparam logic [CODE_W-1:0] CODE_SHORT      = 2'd3;

    // Operation classified by the front part.
    typedef enum logic [2:0] {
        OP_BASE,
        OP_START,
        OP_SAMPLE,
        OP_WRITE,
        OP_READ,
        OP_BAD_INDEX,
        OP_IGNORE
    } t_op;

    typedef struct packed {
        t_op                        op;
        logic [ADDR_W-1:0]          addr;
        logic signed [SAMPLE_W-1:0] sample;
        logic [CODE_W-1:0]          wval;
    } t_cmd;

endpackage

@@ hw/rtl/mscc_front.sv @@
// Front part of the motor short-circuit checker: decodes and classifies input beats.
// Depends on mscc_pkg.
module mscc_front (
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // tdata: row_index[2:0], col_index[5:3], current_sample[21:6], state_value[23:22]
    input  logic [mscc_pkg::S_TDATA_W-1:0]      i_s_tdata,
    // tuser: mode[2:0]
    input  logic [mscc_pkg::S_TUSER_W-1:0]      i_s_tuser,
    output logic                                o_cmd_valid,
    input  logic                                i_cmd_ready,
    output mscc_pkg::t_cmd                      o_cmd
);
    import mscc_pkg::*;

    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             idx_ok;

    assign o_cmd_valid = i_s_tvalid;
    assign o_s_tready  = i_cmd_ready;

    // Index check, table address and operation class.
    always_comb begin
        row    = i_s_tdata[2:0];
        col    = i_s_tdata[5:3];
        idx_ok = (int'(row) < MOTOR_ROWS) && (int'(col) < MOTOR_COLS);

        o_cmd.addr   = idx_ok ? ADDR_W'(int'(row) * MOTOR_COLS + int'(col)) : '0;
        o_cmd.sample = i_s_tdata[21:6];
        o_cmd.wval   = i_s_tdata[23:22];

        case (i_s_tuser)
            MODE_BASELINE: o_cmd.op = OP_BASE;
            MODE_START:    o_cmd.op = idx_ok ? OP_START : OP_BAD_INDEX;
            MODE_SAMPLE:   o_cmd.op = OP_SAMPLE;
            MODE_WRITE:    o_cmd.op = idx_ok ? OP_WRITE : OP_BAD_INDEX;
            MODE_READ:     o_cmd.op = idx_ok ? OP_READ : OP_BAD_INDEX;
            default:       o_cmd.op = OP_IGNORE;
        endcase
    end

endmodule

@@ hw/rtl/mscc_queue.sv @@
// Short command queue that decouples the front and back parts of the checker.
// Depends on mscc_pkg.
module mscc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  mscc_pkg::t_cmd i_push_cmd,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output mscc_pkg::t_cmd o_pop_cmd
);
    import mscc_pkg::*;

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count < QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
        next_ptr = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= next_ptr(r_wr_ptr);
            if (pop)  r_rd_ptr <= next_ptr(r_rd_ptr);
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (push) r_slot[r_wr_ptr] <= i_push_cmd;
    end

endmodule

@@ hw/rtl/mscc_back.sv @@
// Back part of the motor short-circuit checker: baseline, test sequencing, health
// table memory, configuration registers and the result register. Depends on mscc_pkg.
module mscc_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cmd_valid,
    output logic                                o_cmd_ready,
    input  mscc_pkg::t_cmd                      i_cmd,
    input  logic                                i_cfg_wr_en,
    input  logic [mscc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mscc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // tdata: status[2:0], motor_state[4:3], relay_on[5], baseline_level[21:6],
    //        baseline_ready[22], zero[23]
    output logic [mscc_pkg::M_TDATA_W-1:0]      o_m_tdata
);
    import mscc_pkg::*;

    // Configuration registers.
    logic [THR_W-1:0]  r_thr;
    logic [CNT6_W-1:0] r_limit;
    logic [CNT6_W-1:0] r_wlen;

    // Block state.
    logic signed [SUM_W-1:0]    r_sum, n_sum;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic signed [SAMPLE_W-1:0] r_base, n_base;
    logic                       r_bvalid, n_bvalid;
    logic                       r_active, n_active;
    logic [ADDR_W-1:0]          r_taddr, n_taddr;
    logic [CNT6_W-1:0]          r_win, n_win;
    logic [CNT6_W-1:0]          r_exc, n_exc;
    logic                       r_div_pend, n_div_pend;
    logic signed [SUM_W-1:0]    r_div_sum, n_div_sum;

    // Health table memory and its valid bits.
    logic [CODE_W-1:0]     r_table [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] r_tvalid;
    logic [CODE_W-1:0]     r_rd_data;
    logic                  r_rd_ok;
    logic                  tbl_we;
    logic [ADDR_W-1:0]     tbl_waddr;
    logic [CODE_W-1:0]     tbl_wdata;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;

    // Result register.
    logic                       r_out_valid;
    logic [STATUS_W-1:0]        r_out_status;
    logic [CODE_W-1:0]          r_out_mstate;
    logic                       r_out_use_rd;
    logic                       r_out_active;
    logic signed [SAMPLE_W-1:0] r_out_base;
    logic                       r_out_bvalid;
    logic                       out_load;
    logic [STATUS_W-1:0]        out_status;
    logic [CODE_W-1:0]          out_mstate;
    logic                       out_use_rd;
    logic [CODE_W-1:0]          out_code;

    // Datapath helpers.
    logic                         adv;
    logic                         take;
    logic signed [SUM_W-1:0]      sum_add;
    logic [CNT_W-1:0]             cnt_inc;
    logic signed [SAMPLE_W+1:0]   diff;
    logic                         exceed;
    logic [CNT6_W-1:0]            exc_inc;
    logic [CNT6_W-1:0]            win_inc;
    logic                         div_neg;
    logic [SUM_W-1:0]             div_mag;
    logic [SUM_W+DIV_SHIFT:0]     div_prod;
    logic [SAMPLE_W:0]            div_q;
    logic [SAMPLE_W:0]            div_res;

    assign adv         = !r_out_valid || i_m_tready;
    assign o_cmd_ready = adv && !r_div_pend;
    assign take        = o_cmd_ready && i_cmd_valid;

    // Baseline accumulate and test-sample compare.
    assign sum_add = r_sum + {{(SUM_W - SAMPLE_W){i_cmd.sample[SAMPLE_W-1]}}, i_cmd.sample};
    assign cnt_inc = r_cnt + 1'b1;
    assign diff    = {{2{i_cmd.sample[SAMPLE_W-1]}}, i_cmd.sample}
                   - {{2{r_base[SAMPLE_W-1]}}, r_base};
    assign exceed  = (diff > $signed({3'b000, r_thr}));
    assign exc_inc = exceed ? r_exc + 1'b1 : r_exc;
    assign win_inc = r_win + 1'b1;

    // Divide the completed sum by the sample count through a reciprocal multiply.
    assign div_neg  = r_div_sum[SUM_W-1];
    assign div_mag  = div_neg ? (~$unsigned(r_div_sum) + 1'b1) : $unsigned(r_div_sum);
    assign div_prod = (SUM_W + DIV_SHIFT + 1)'(div_mag)
                    * (SUM_W + DIV_SHIFT + 1)'(DIV_MULT);
    assign div_q    = div_prod[DIV_SHIFT +: SAMPLE_W + 1];
    assign div_res  = div_neg ? (~div_q + 1'b1) : div_q;

    // Execute one command, or finish a pending baseline average.
    always_comb begin
        n_sum      = r_sum;
        n_cnt      = r_cnt;
        n_base     = r_base;
        n_bvalid   = r_bvalid;
        n_active   = r_active;
        n_taddr    = r_taddr;
        n_win      = r_win;
        n_exc      = r_exc;
        n_div_pend = r_div_pend;
        n_div_sum  = r_div_sum;
        tbl_we     = 1'b0;
        tbl_waddr  = i_cmd.addr;
        tbl_wdata  = i_cmd.wval;
        rd_en      = 1'b0;
        rd_addr    = i_cmd.addr;
        out_load   = 1'b0;
        out_status = ST_IGNORED;
        out_mstate = CODE_FUNCTIONAL;
        out_use_rd = 1'b0;

        if (r_div_pend) begin
            if (adv) begin
                n_base     = div_res[SAMPLE_W-1:0];
                n_bvalid   = 1'b1;
                n_div_pend = 1'b0;
                out_load   = 1'b1;
                out_status = ST_ACCEPTED;
            end
        end else if (take) begin
            out_load = 1'b1;
            case (i_cmd.op)
                OP_BASE: begin
                    if (!r_active) begin
                        out_status = ST_ACCEPTED;
                        if (cnt_inc >= CNT_W'(BASELINE_SAMPLES)) begin
                            // The sum is registered in r_div_sum; the result is loaded once the divide completes.
                            n_div_sum  = sum_add;
                            n_sum      = '0;
                            n_cnt      = '0;
                            n_div_pend = 1'b1;
                            out_load   = 1'b0;
                        end else begin
                            n_sum = sum_add;
                            n_cnt = cnt_inc;
                        end
                    end
                end
                OP_START: begin
                    if (!r_active && r_bvalid) begin
                        n_active   = 1'b1;
                        n_taddr    = i_cmd.addr;
                        n_win      = '0;
                        n_exc      = '0;
                        out_status = ST_ACCEPTED;
                    end
                end
                OP_SAMPLE: begin
                    if (r_active) begin
                        n_exc     = exc_inc;
                        n_win     = win_inc;
                        tbl_waddr = r_taddr;
                        rd_addr   = r_taddr;
                        if (exc_inc >= r_limit) begin
                            tbl_we     = 1'b1;
                            tbl_wdata  = CODE_SHORT;
                            n_active   = 1'b0;
                            out_status = ST_SHORT;
                            out_mstate = CODE_SHORT;
                        end else if (win_inc >= r_wlen) begin
                            tbl_we     = 1'b1;
                            tbl_wdata  = CODE_FUNCTIONAL;
                            n_active   = 1'b0;
                            out_status = ST_PASSED;
                            out_mstate = CODE_FUNCTIONAL;
                        end else begin
                            rd_en      = 1'b1;
                            out_use_rd = 1'b1;
                            out_status = ST_ACCEPTED;
                        end
                    end
                end
                OP_WRITE: begin
                    tbl_we     = 1'b1;
                    out_mstate = i_cmd.wval;
                    out_status = ST_ACCEPTED;
                end
                OP_READ: begin
                    rd_en      = 1'b1;
                    out_use_rd = 1'b1;
                    out_status = ST_ACCEPTED;
                end
                OP_BAD_INDEX: begin
                    out_status = ST_BAD_INDEX;
                end
                default: begin
                    out_status = ST_IGNORED;
                end
            endcase
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= RST_IDLE_THRESHOLD;
            r_limit <= RST_FAULT_COUNT_LIMIT;
            r_wlen  <= RST_WINDOW_LENGTH;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_IDLE_THRESHOLD:    r_thr   <= i_cfg_data[THR_W-1:0];
                CFG_FAULT_COUNT_LIMIT: r_limit <= i_cfg_data[CNT6_W-1:0];
                CFG_WINDOW_LENGTH:     r_wlen  <= i_cfg_data[CNT6_W-1:0];
                default: ;
            endcase
        end
    end

    // Block state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_cnt      <= '0;
            r_base     <= '0;
            r_bvalid   <= 1'b0;
            r_active   <= 1'b0;
            r_taddr    <= '0;
            r_win      <= '0;
            r_exc      <= '0;
            r_div_pend <= 1'b0;
            r_div_sum  <= '0;
        end else begin
            r_sum      <= n_sum;
            r_cnt      <= n_cnt;
            r_base     <= n_base;
            r_bvalid   <= n_bvalid;
            r_active   <= n_active;
            r_taddr    <= n_taddr;
            r_win      <= n_win;
            r_exc      <= n_exc;
            r_div_pend <= n_div_pend;
            r_div_sum  <= n_div_sum;
        end
    end

    // Health table memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (tbl_we) r_table[tbl_waddr] <= tbl_wdata;
        if (rd_en) begin
            r_rd_data <= r_table[rd_addr];
            r_rd_ok   <= r_tvalid[rd_addr];
        end
    end

    // Entry valid bits; an entry never written reads as functional.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= '0;
        end else if (tbl_we) begin
            r_tvalid[tbl_waddr] <= 1'b1;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= out_status;
            r_out_mstate <= out_mstate;
            r_out_use_rd <= out_use_rd;
            r_out_active <= n_active;
            r_out_base   <= n_base;
            r_out_bvalid <= n_bvalid;
        end
    end

    assign out_code   = r_out_use_rd ? (r_rd_ok ? r_rd_data : CODE_FUNCTIONAL) : r_out_mstate;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_bvalid, r_out_base, r_out_active, out_code, r_out_status};

endmodule

@@ hw/rtl/motor_short_circuit_checker.sv @@
// Path: an accepted input beat is held in the command queue slot and then in the result
// register; the beat that completes a baseline average also passes through the divide
// register (r_div_sum) for the reciprocal-multiply divide. Throughput: one beat per cycle
// otherwise, while the output is not stalled and no divide is pending, set by the execute
// stage in the back part. Reset (i_rst_n low, synchronous) clears the control state, loads
// the configuration defaults and clears the health table valid bits at once.
module motor_short_circuit_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // tdata: row_index[2:0], col_index[5:3], current_sample[21:6], state_value[23:22]
    input  logic [mscc_pkg::S_TDATA_W-1:0]      i_s_tdata,
    // tuser: mode[2:0]
    input  logic [mscc_pkg::S_TUSER_W-1:0]      i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // tdata: status[2:0], motor_state[4:3], relay_on[5], baseline_level[21:6],
    //        baseline_ready[22], zero[23]
    output logic [mscc_pkg::M_TDATA_W-1:0]      o_m_tdata,
    input  logic                                i_cfg_wr_en,
    input  logic [mscc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mscc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import mscc_pkg::*;

    logic front_valid;
    logic front_ready;
    t_cmd front_cmd;
    logic back_valid;
    logic back_ready;
    t_cmd back_cmd;

    // Decode and classify.
    mscc_front u_front (
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready),
        .o_cmd       (front_cmd)
    );

    // Decoupling queue.
    mscc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_cmd   (front_cmd),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_cmd    (back_cmd)
    );

    // Execute and deliver results.
    mscc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (back_valid),
        .o_cmd_ready (back_ready),
        .i_cmd       (back_cmd),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

@@ hw/rtl/mscc_checker.sv @@
// Port-level checker for the motor short-circuit checker, bound to the top level.
// Depends on mscc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mscc_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [mscc_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import mscc_pkg::*;

    // A stalled result beat keeps its data.
    `ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "result beat changed while stalled")

    // Once a baseline exists it stays valid on every later beat.
    `ASSERT_NEXT(a_baseline_sticky, o_m_tvalid && i_m_tready && o_m_tdata[22], !o_m_tvalid || o_m_tdata[22], "baseline ready dropped")

    // A test verdict always drops the relay.
    `ASSERT_IMPLIES(a_verdict_relay, o_m_tvalid && (o_m_tdata[2:0] == ST_SHORT || o_m_tdata[2:0] == ST_PASSED), !o_m_tdata[5], "relay still on after a verdict")

    // A bad index reports a zero health code.
    `ASSERT_IMPLIES(a_bad_index_code, o_m_tvalid && o_m_tdata[2:0] == ST_BAD_INDEX, o_m_tdata[4:3] == CODE_FUNCTIONAL, "bad index beat carries a health code")

endmodule

bind motor_short_circuit_checker mscc_checker u_checker (.*);
